@@ sv/dns_name_wildcard_match_core_assert.svh @@
// ----------------------------------------------------------------------------
// dns_name_wildcard_match_core_assert.svh
// Assertion macros used by the wildcard match core RTL.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_WILDCARD_MATCH_CORE_ASSERT_SVH
`define DNS_NAME_WILDCARD_MATCH_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DNSWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dnswm assertion failed");

// next-cycle implication, checked outside reset
`define DNSWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dnswm assertion failed");

`endif

@@ sv/dnswm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnswm_pkg
// Constants, types and helpers for the DNS name wildcard matcher.
// ----------------------------------------------------------------------------
package dnswm_pkg;

    // name buffer
    localparam int NAME_BYTES = 32;
    localparam int NAME_AW    = $clog2(NAME_BYTES);
    localparam int LEN_W      = $clog2(NAME_BYTES + 1);

    // pattern (four 64-bit registers)
    localparam int PAT_BYTES  = 32;
    localparam int PAT_AW     = $clog2(PAT_BYTES);
    localparam int PI_W       = $clog2(PAT_BYTES + 1);
    localparam int CFG_REGS   = 4;
    localparam int CFG_AW     = 5;

    // characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UPW   = 8'h57;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7A;

    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    // request from the collector to the matcher
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] name_len;
        logic             name_www;
    } t_match_ctl;

    // matcher completion
    typedef struct packed {
        logic done;
        logic matched;
    } t_match_res;

    // ASCII upper-case fold, letters only
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOA && c <= CH_LOZ) begin
            r = c - CH_SPACE;
        end
        return r;
    endfunction

endpackage

@@ sv/dnswm_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnswm_match
// Iterative glob matcher: one pattern/name compare step per cycle with
// single-star backtracking; the name is read from a registered memory port.
// ----------------------------------------------------------------------------
module dnswm_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dnswm_pkg::t_pattern         i_pattern,
    input  dnswm_pkg::t_match_ctl       i_ctl,
    input  logic [7:0]                  i_name_rd_data,
    output logic [dnswm_pkg::NAME_AW-1:0] o_name_rd_addr,
    output dnswm_pkg::t_match_res       o_res
);

    localparam logic M_IDLE = 1'b0;
    localparam logic M_RUN  = 1'b1;

    logic                          r_state, n_state;
    logic [dnswm_pkg::PI_W-1:0]    r_pi, n_pi, r_star_p, n_star_p;
    logic [dnswm_pkg::LEN_W-1:0]   r_si, n_si, r_star_s, n_star_s, r_sl, n_sl;
    logic                          r_have_star, n_have_star;

    logic [7:0] w_pc;
    logic       w_pend;
    logic       w_star0, w_pat_www, w_strip;
    logic       w_eq;

    // current pattern character, zero once past the end
    always_comb begin
        if (r_pi == dnswm_pkg::PI_W'(dnswm_pkg::PAT_BYTES)) begin
            w_pc = 8'h00;
        end else begin
            w_pc = i_pattern[r_pi[dnswm_pkg::PAT_AW-1:0]];
        end
    end
    assign w_pend = (w_pc == 8'h00);
    assign w_eq   = (w_pc == dnswm_pkg::CH_QUEST) ||
                    (dnswm_pkg::fold_case(w_pc) == dnswm_pkg::fold_case(i_name_rd_data));

    // leading www. handling on the pattern
    assign w_star0   = (i_pattern[0] == dnswm_pkg::CH_STAR);
    assign w_pat_www = (dnswm_pkg::fold_case(i_pattern[0]) == dnswm_pkg::CH_UPW) &&
                       (dnswm_pkg::fold_case(i_pattern[1]) == dnswm_pkg::CH_UPW) &&
                       (dnswm_pkg::fold_case(i_pattern[2]) == dnswm_pkg::CH_UPW) &&
                       (i_pattern[3] == dnswm_pkg::CH_DOT);
    assign w_strip   = !w_star0;

    // step sequencer
    always_comb begin
        n_state     = r_state;
        n_pi        = r_pi;
        n_si        = r_si;
        n_sl        = r_sl;
        n_star_p    = r_star_p;
        n_star_s    = r_star_s;
        n_have_star = r_have_star;
        o_res       = '0;
        case (r_state)
            M_IDLE: begin
                if (i_ctl.start) begin
                    n_state     = M_RUN;
                    n_sl        = i_ctl.name_len;
                    n_have_star = 1'b0;
                    n_star_p    = '0;
                    n_star_s    = '0;
                    n_pi        = (w_strip && w_pat_www) ? dnswm_pkg::PI_W'(4) : '0;
                    n_si        = (w_strip && i_ctl.name_www) ? dnswm_pkg::LEN_W'(4) : '0;
                end
            end
            M_RUN: begin
                if (r_si != r_sl) begin
                    if (!w_pend && w_pc == dnswm_pkg::CH_STAR) begin
                        n_have_star = 1'b1;
                        n_star_p    = r_pi;
                        n_pi        = r_pi + 1'b1;
                        n_star_s    = r_si;
                    end else if (!w_pend && w_eq) begin
                        n_pi = r_pi + 1'b1;
                        n_si = r_si + 1'b1;
                    end else if (r_have_star) begin
                        n_pi     = r_star_p + 1'b1;
                        n_star_s = r_star_s + 1'b1;
                        n_si     = r_star_s + 1'b1;
                    end else begin
                        o_res.done    = 1'b1;
                        o_res.matched = 1'b0;
                        n_state       = M_IDLE;
                    end
                end else begin
                    // name consumed: only trailing stars may remain
                    if (!w_pend && w_pc == dnswm_pkg::CH_STAR) begin
                        n_pi = r_pi + 1'b1;
                    end else begin
                        o_res.done    = 1'b1;
                        o_res.matched = w_pend;
                        n_state       = M_IDLE;
                    end
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // read the byte the next step needs
    assign o_name_rd_addr = n_si[dnswm_pkg::NAME_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_have_star <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_star <= n_have_star;
        end
        r_pi     <= n_pi;
        r_si     <= n_si;
        r_sl     <= n_sl;
        r_star_p <= n_star_p;
        r_star_s <= n_star_s;
    end

endmodule

@@ sv/dns_name_wildcard_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_wildcard_match_core
// Collects a DNS question name and glob-matches it against a pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one name byte per word in s_tdata[7:0], s_tlast on the
//   final byte of a name. Bytes are taken one per cycle while collecting.
//   Bytes below 0x20 are stored as '.', a zero byte ends the name, and
//   bytes beyond 32 stored ones are dropped.
//   After the word with s_tlast, s_tready drops for the match: a setup
//   state (S_START), then one compare step per cycle in the matcher (a step
//   advances the pattern or the name, backtracks to the last star, or
//   decides), and m_tvalid is registered from the deciding step when the
//   output register is free; steps is at most name length + pattern length
//   + 1 without backtracking and about (name + 1) x (pattern + 1) (some
//   1100) at worst.
//   Master stream: one word per name, m_tdata[0] = matched.
//   The result sits in an output register; the next name is collected
//   while it waits. A second result waits in a hold register until the
//   first is taken, holding s_tready low.
//   Pattern: four 64-bit APB registers at 0x00, 0x08, 0x10, 0x18.
//   Reset (synchronous, active low) clears the pattern, the name count and
//   the output valid.
// ----------------------------------------------------------------------------
`include "dns_name_wildcard_match_core_assert.svh"

module dns_name_wildcard_match_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // name byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] name_byte
    input  logic                        s_tlast,   // is_last
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [0] matched, [7:1] zero
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dnswm_pkg::CFG_AW-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_START   = 2'd1;
    localparam logic [1:0] S_MATCH   = 2'd2;
    localparam logic [1:0] S_HOLD    = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [63:0]                    r_pat_reg [dnswm_pkg::CFG_REGS];
    logic [dnswm_pkg::LEN_W-1:0]    r_len, n_len;
    logic                           r_ended, n_ended;
    logic                           r_www_ok, n_www_ok;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_match, n_out_match;
    logic                           r_hold_match, n_hold_match;
    logic [7:0]                     r_name_mem [dnswm_pkg::NAME_BYTES];
    logic [7:0]                     r_rd_data;

    logic                           w_accept, w_store, w_out_free, w_www_pos;
    logic [7:0]                     w_char;
    logic [1:0]                     w_cfg_sel;
    dnswm_pkg::t_pattern            w_pattern;
    dnswm_pkg::t_match_ctl          w_ctl;
    dnswm_pkg::t_match_res          w_res;
    logic [dnswm_pkg::NAME_AW-1:0]  w_rd_addr;
    logic                           w_len_ok, w_cleared, w_match_done;

    // APB register file
    assign pready    = 1'b1;
    assign w_cfg_sel = paddr[4:3];
    assign prdata    = r_pat_reg[w_cfg_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dnswm_pkg::CFG_REGS; i++) begin
                r_pat_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            r_pat_reg[w_cfg_sel] <= pwdata;
        end
    end

    assign w_pattern = {r_pat_reg[3], r_pat_reg[2], r_pat_reg[1], r_pat_reg[0]};

    // byte collection
    assign s_tready   = (r_state == S_COLLECT);
    assign w_accept   = s_tvalid && s_tready;
    assign w_store    = w_accept && !r_ended && (s_tdata != 8'h00) &&
                        (r_len < dnswm_pkg::LEN_W'(dnswm_pkg::NAME_BYTES));
    assign w_char     = (s_tdata < dnswm_pkg::CH_SPACE) ? dnswm_pkg::CH_DOT : s_tdata;
    assign w_out_free = !r_out_valid || m_tready;
    assign w_www_pos  = (r_len < dnswm_pkg::LEN_W'(4));

    // name memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_name_mem[r_len[dnswm_pkg::NAME_AW-1:0]] <= w_char;
        end
        r_rd_data <= r_name_mem[w_rd_addr];
    end

    // matcher request
    assign w_ctl.start    = (r_state == S_START);
    assign w_ctl.name_len = r_len;
    assign w_ctl.name_www = r_www_ok && (r_len >= dnswm_pkg::LEN_W'(4));

    dnswm_match u_match (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pattern      (w_pattern),
        .i_ctl          (w_ctl),
        .i_name_rd_data (r_rd_data),
        .o_name_rd_addr (w_rd_addr),
        .o_res          (w_res)
    );

    // control sequencer
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_ended      = r_ended;
        n_www_ok     = r_www_ok;
        n_hold_match = r_hold_match;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_match  = r_out_match;
        case (r_state)
            S_COLLECT: begin
                if (w_accept && !r_ended && s_tdata == 8'h00) begin
                    n_ended = 1'b1;
                end
                if (w_store) begin
                    n_len = r_len + 1'b1;
                    // track a leading "www." as it is stored
                    if (w_www_pos) begin
                        if (r_len == dnswm_pkg::LEN_W'(3)) begin
                            n_www_ok = r_www_ok && (w_char == dnswm_pkg::CH_DOT);
                        end else begin
                            n_www_ok = ((r_len == '0) || r_www_ok) &&
                                       (dnswm_pkg::fold_case(w_char) == dnswm_pkg::CH_UPW);
                        end
                    end
                end
                if (w_accept && s_tlast) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_MATCH;
            end
            S_MATCH: begin
                if (w_res.done) begin
                    n_len    = '0;
                    n_ended  = 1'b0;
                    n_www_ok = 1'b0;
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_match = w_res.matched;
                        n_state     = S_COLLECT;
                    end else begin
                        n_hold_match = w_res.matched;
                        n_state      = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_match = r_hold_match;
                    n_state     = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_len       <= '0;
            r_ended     <= 1'b0;
            r_www_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ended     <= n_ended;
            r_www_ok    <= n_www_ok;
            r_out_valid <= n_out_valid;
        end
        r_out_match  <= n_out_match;
        r_hold_match <= n_hold_match;
    end

    // result word
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_match};

    // checks
    assign w_len_ok     = (r_len <= dnswm_pkg::LEN_W'(dnswm_pkg::NAME_BYTES));
    assign w_cleared    = (r_len == '0) && !r_ended;
    assign w_match_done = (r_state == S_MATCH) && w_res.done;

    `DNSWM_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, w_len_ok)
    `DNSWM_ASSERT_NOW(a_done_in_match, i_clk, i_rst_n, w_res.done, r_state == S_MATCH)
    `DNSWM_ASSERT_NEXT(a_clear_after_done, i_clk, i_rst_n, w_match_done, w_cleared)
    `DNSWM_ASSERT_NEXT(a_start_once, i_clk, i_rst_n, r_state == S_START, r_state == S_MATCH)

endmodule
